// File: rtl/gjd_pkg.sv
// ----------------------------------------------------------------------------
// gjd_pkg
// Types, calendar constants and month tables for the Gregorian to Jalali
// date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package gjd_pkg;

	typedef struct packed {
		logic [13:0] greg_year;
		logic [3:0]  greg_month;
		logic [4:0]  greg_day;
	} greg_date_t;

	typedef struct packed {
		logic signed [14:0] persian_year;
		logic [3:0]         persian_month;
		logic [4:0]         persian_day;
		logic [8:0]         day_in_year;
	} jalali_date_t;

	localparam logic [23:0] EPOCH_475    = 24'd2121446;
	localparam logic [23:0] CYCLE_DAYS   = 24'd1029983;
	localparam logic [23:0] CYCLE_LAST   = 24'd1029982;
	localparam logic [12:0] CYCLE_YEARS  = 13'd2820;
	localparam logic [23:0] LEAP_DIV     = 24'd1028522;
	localparam logic [23:0] LEAP_MUL     = 24'd2134;
	localparam logic [23:0] LEAP_SCALE   = 24'd2816;
	localparam logic [22:0] EPY_MUL      = 23'd682;
	localparam logic [25:0] PERSIAN_BASE = 26'd1948320;
	localparam logic [25:0] GREG_ADJ     = 26'd32075;
	localparam logic [25:0] JUL_ADJ      = 26'd1729777;
	localparam logic [25:0] DAYS_4Y      = 26'd1461;
	localparam logic [16:0] YEAR_474     = 17'd474;
	localparam logic [16:0] YEAR_473     = 17'd473;

	// (367 * m') / 12 with the month shifted to start in March
	function automatic logic [8:0] greg_month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd0:    t = 9'd305;
			4'd1:    t = 9'd336;
			4'd2:    t = 9'd367;
			4'd3:    t = 9'd30;
			4'd4:    t = 9'd61;
			4'd5:    t = 9'd91;
			4'd6:    t = 9'd122;
			4'd7:    t = 9'd152;
			4'd8:    t = 9'd183;
			4'd9:    t = 9'd214;
			4'd10:   t = 9'd244;
			4'd11:   t = 9'd275;
			4'd12:   t = 9'd305;
			4'd13:   t = 9'd336;
			4'd14:   t = 9'd367;
			4'd15:   t = 9'd397;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

	// (275 * m) / 9
	function automatic logic [8:0] jul_month_term(input logic [3:0] m);
		logic [8:0] t;
		case (m)
			4'd0:    t = 9'd0;
			4'd1:    t = 9'd30;
			4'd2:    t = 9'd61;
			4'd3:    t = 9'd91;
			4'd4:    t = 9'd122;
			4'd5:    t = 9'd152;
			4'd6:    t = 9'd183;
			4'd7:    t = 9'd213;
			4'd8:    t = 9'd244;
			4'd9:    t = 9'd275;
			4'd10:   t = 9'd305;
			4'd11:   t = 9'd336;
			4'd12:   t = 9'd366;
			4'd13:   t = 9'd397;
			4'd14:   t = 9'd427;
			4'd15:   t = 9'd458;
			default: t = 9'd0;
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

// File: rtl/gregorian_to_jalali_date.sv
// ----------------------------------------------------------------------------
// gregorian_to_jalali_date
// Converts a civil (Gregorian, Julian before the 1582 reform) date into a
// Jalali date and day of year through a day number and the 2820-year cycle.
// ----------------------------------------------------------------------------
// Usage:
//   greg channel: one date request per cycle when greg_valid is high and
//   greg_stall is low. jalali channel: one result per request, in order,
//   taken when jalali_valid is high and jalali_stall is low.
//   jalali_valid is the valid bit of stage 19, the result register;
//   throughput is one date per cycle while jalali_stall stays low. The 19
//   register stages each hold at most one constant reciprocal multiply or
//   a short add chain.
//   Each stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles close up and a new request is taken
//   while a finished result waits. greg_stall rises only when all 19 stages
//   hold requests and the receiver stalls.
//   Reset clears all valid bits. A stalled result holds its value until
//   jalali_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

module gregorian_to_jalali_date
	import gjd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         greg_valid,
	output logic         greg_stall,
	input  greg_date_t   greg,
	output logic         jalali_valid,
	input  logic         jalali_stall,
	output jalali_date_t jalali
);

	localparam int NS = 19;

	// reciprocals, exact for the operand widths used below
	localparam logic [15:0] M_100  = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
	localparam logic [23:0] M_CYC  = 24'(((64'd1 << 43) + 64'(CYCLE_DAYS) - 64'd1)
		/ 64'(CYCLE_DAYS));
	localparam logic [20:0] M_366  = 21'(((64'd1 << 29) + 64'd365) / 64'd366);
	localparam logic [23:0] M_NUM  = 24'(((64'd1 << 43) + 64'(LEAP_DIV) - 64'd1)
		/ 64'(LEAP_DIV));
	localparam logic [15:0] M_2820 = 16'(((64'd1 << 27) + 64'd2819) / 64'd2820);
	localparam logic [22:0] M_2816 = 23'(((64'd1 << 34) + 64'd2815) / 64'd2816);
	localparam logic [26:0] M_31   = 27'(((64'd1 << 31) + 64'd30) / 64'd31);
	localparam logic [26:0] M_30   = 27'(((64'd1 << 31) + 64'd29) / 64'd30);

	logic [NS:1] stage_vld_q;
	logic [NS:1] adv;

	always_comb begin
		adv[NS] = !stage_vld_q[NS] || !jalali_stall;
		for (int k = NS - 1; k >= 1; k--) begin
			adv[k] = !stage_vld_q[k] || adv[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			for (int k = NS; k >= 2; k--) begin
				if (adv[k]) begin
					stage_vld_q[k] <= stage_vld_q[k - 1];
				end
			end
			if (adv[1]) begin
				stage_vld_q[1] <= greg_valid;
			end
		end
	end

	assign greg_stall   = !adv[1];
	assign jalali_valid = stage_vld_q[NS];

	// ---- stage 1: calendar select, century quotient, month terms
	logic        early;
	logic        greg_sel;
	logic [14:0] gh;
	logic [30:0] p100;

	always_comb begin
		early    = (greg.greg_month <= 4'd2);
		greg_sel = (greg.greg_year > 14'd1582)
			|| (greg.greg_year == 14'd1582 && greg.greg_month > 4'd10)
			|| (greg.greg_year == 14'd1582 && greg.greg_month == 4'd10
				&& greg.greg_day > 5'd14);
		gh   = 15'(greg.greg_year) + 15'd4900 - 15'(early);
		p100 = 31'(gh) * 31'(M_100);
	end

	logic        sel_s1;
	logic [14:0] ga_s1;
	logic [14:0] ja_s1;
	logic [8:0]  y100_s1;
	logic [8:0]  mterm_s1;
	logic [13:0] gy_s1;
	logic [4:0]  gd_s1;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sel_s1   <= greg_sel;
			ga_s1    <= 15'(greg.greg_year) + 15'd4800 - 15'(early);
			ja_s1    <= 15'(greg.greg_year) + 15'd5001 - 15'(early);
			y100_s1  <= p100[30:22];
			mterm_s1 <= greg_sel ? greg_month_term(greg.greg_month)
				: jul_month_term(greg.greg_month);
			gy_s1    <= greg.greg_year;
			gd_s1    <= greg.greg_day;
		end
	end

	// ---- stage 2: day number
	logic [25:0] gsum;
	logic [25:0] jsum;

	always_comb begin
		gsum = ((26'(ga_s1) * DAYS_4Y) >> 2) + 26'(mterm_s1) + 26'(gd_s1)
			- ((26'(y100_s1) * 26'd3) >> 2) - GREG_ADJ;
		jsum = 26'(gy_s1) * 26'd367 + 26'(mterm_s1) + 26'(gd_s1) + JUL_ADJ
			- ((26'(ja_s1) * 26'd7) >> 2);
	end

	logic [22:0] jdn_s2;

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			jdn_s2 <= sel_s1 ? gsum[22:0] : jsum[22:0];
		end
	end

	// ---- stage 3: offset from epoch and cycle count
	logic [23:0] dep;
	logic [46:0] pcyc;

	always_comb begin
		dep  = 24'(jdn_s2) - EPOCH_475;
		pcyc = 47'(dep[22:0]) * 47'(M_CYC);
	end

	logic [23:0] dep_s3;
	logic [3:0]  cyc_s3;
	logic [22:0] jdn_s3;

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			dep_s3 <= dep;
			cyc_s3 <= dep[23] ? 4'd0 : pcyc[46:43];
			jdn_s3 <= jdn_s2;
		end
	end

	// ---- stage 4: day within cycle, sign and magnitude
	logic [23:0] rem_u;
	logic [23:0] rem_abs;

	always_comb begin
		rem_u   = dep_s3 - 24'(cyc_s3) * CYCLE_DAYS;
		rem_abs = rem_u[23] ? (24'd0 - rem_u) : rem_u;
	end

	logic        last_s4;
	logic        rem_neg_s4;
	logic [19:0] rem_mag_s4;
	logic [3:0]  cyc_s4;
	logic [22:0] jdn_s4;

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			last_s4    <= (rem_u == CYCLE_LAST);
			rem_neg_s4 <= rem_u[23];
			rem_mag_s4 <= rem_abs[19:0];
			cyc_s4     <= cyc_s3;
			jdn_s4     <= jdn_s3;
		end
	end

	// ---- stage 5: divide by 366
	logic [40:0] p366;

	assign p366 = 41'(rem_mag_s4) * 41'(M_366);

	logic [11:0] ua_s5;
	logic        last_s5;
	logic        rem_neg_s5;
	logic [19:0] rem_mag_s5;
	logic [3:0]  cyc_s5;
	logic [22:0] jdn_s5;

	always_ff @(posedge clk) begin
		if (adv[5]) begin
			ua_s5      <= p366[40:29];
			last_s5    <= last_s4;
			rem_neg_s5 <= rem_neg_s4;
			rem_mag_s5 <= rem_mag_s4;
			cyc_s5     <= cyc_s4;
			jdn_s5     <= jdn_s4;
		end
	end

	// ---- stage 6: truncating quotient and remainder by 366
	logic [19:0] ur_full;
	logic [12:0] a_u;
	logic [9:0]  r_u;

	always_comb begin
		ur_full = rem_mag_s5 - 20'(ua_s5) * 20'd366;
		a_u     = {1'b0, ua_s5};
		r_u     = {1'b0, ur_full[8:0]};
	end

	logic signed [12:0] a_s6;
	logic signed [9:0]  r_s6;
	logic               last_s6;
	logic [3:0]         cyc_s6;
	logic [22:0]        jdn_s6;

	always_ff @(posedge clk) begin
		if (adv[6]) begin
			a_s6    <= rem_neg_s5 ? $signed(13'd0 - a_u) : $signed(a_u);
			r_s6    <= rem_neg_s5 ? $signed(10'd0 - r_u) : $signed(r_u);
			last_s6 <= last_s5;
			cyc_s6  <= cyc_s5;
			jdn_s6  <= jdn_s5;
		end
	end

	// ---- stage 7: leap numerator
	logic [23:0] num;
	logic [23:0] num_abs;

	always_comb begin
		num = $unsigned(24'(a_s6)) * LEAP_MUL + $unsigned(24'(r_s6)) * LEAP_SCALE
			+ 24'd2815;
		num_abs = num[23] ? (24'd0 - num) : num;
	end

	logic               num_neg_s7;
	logic [22:0]        num_mag_s7;
	logic signed [12:0] a_s7;
	logic               last_s7;
	logic [3:0]         cyc_s7;
	logic [22:0]        jdn_s7;

	always_ff @(posedge clk) begin
		if (adv[7]) begin
			num_neg_s7 <= num[23];
			num_mag_s7 <= num_abs[22:0];
			a_s7       <= a_s6;
			last_s7    <= last_s6;
			cyc_s7     <= cyc_s6;
			jdn_s7     <= jdn_s6;
		end
	end

	// ---- stage 8: year within cycle
	logic [46:0] pnum;
	logic [12:0] nq_u;
	logic [12:0] ycyc_u;

	always_comb begin
		pnum   = 47'(num_mag_s7) * 47'(M_NUM);
		nq_u   = 13'(pnum[46:43]);
		ycyc_u = (num_neg_s7 ? (13'd0 - nq_u) : nq_u) + $unsigned(a_s7) + 13'd1;
	end

	logic [12:0] ycyc_s8;
	logic [3:0]  cyc_s8;
	logic [22:0] jdn_s8;

	always_ff @(posedge clk) begin
		if (adv[8]) begin
			ycyc_s8 <= last_s7 ? CYCLE_YEARS : ycyc_u;
			cyc_s8  <= cyc_s7;
			jdn_s8  <= jdn_s7;
		end
	end

	// ---- stage 9: persian year, year zero skipped
	logic [16:0] yr_u;

	assign yr_u = {{4{ycyc_s8[12]}}, ycyc_s8} + 17'(cyc_s8) * 17'(CYCLE_YEARS) + YEAR_474;

	logic signed [16:0] year_s9;
	logic [22:0]        jdn_s9;

	always_ff @(posedge clk) begin
		if (adv[9]) begin
			year_s9 <= ($signed(yr_u) <= 17'sd0) ? $signed(yr_u - 17'd1) : $signed(yr_u);
			jdn_s9  <= jdn_s8;
		end
	end

	// ---- stage 10: base year for the forward day number
	logic [16:0] base_u;
	logic [16:0] base_abs;

	always_comb begin
		base_u   = $unsigned(year_s9) - YEAR_473 - 17'(!year_s9[16]);
		base_abs = base_u[16] ? (17'd0 - base_u) : base_u;
	end

	logic               base_neg_s10;
	logic [14:0]        base_mag_s10;
	logic signed [16:0] year_s10;
	logic [22:0]        jdn_s10;

	always_ff @(posedge clk) begin
		if (adv[10]) begin
			base_neg_s10 <= base_u[16];
			base_mag_s10 <= base_abs[14:0];
			year_s10     <= year_s9;
			jdn_s10      <= jdn_s9;
		end
	end

	// ---- stage 11: divide base by 2820
	logic [30:0] p2820;

	assign p2820 = 31'(base_mag_s10) * 31'(M_2820);

	logic [3:0]         bq_s11;
	logic               base_neg_s11;
	logic [14:0]        base_mag_s11;
	logic signed [16:0] year_s11;
	logic [22:0]        jdn_s11;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			bq_s11       <= p2820[30:27];
			base_neg_s11 <= base_neg_s10;
			base_mag_s11 <= base_mag_s10;
			year_s11     <= year_s10;
			jdn_s11      <= jdn_s10;
		end
	end

	// ---- stage 12: year within the 2820-year cycle
	logic [14:0] bm_full;
	logic [12:0] bm_u;
	logic [4:0]  bq_u;

	always_comb begin
		bm_full = base_mag_s11 - 15'(bq_s11) * 15'(CYCLE_YEARS);
		bm_u    = {1'b0, bm_full[11:0]};
		bq_u    = {1'b0, bq_s11};
	end

	logic signed [12:0] epy_s12;
	logic signed [4:0]  bq_s12;
	logic signed [16:0] year_s12;
	logic [22:0]        jdn_s12;

	always_ff @(posedge clk) begin
		if (adv[12]) begin
			epy_s12  <= $signed(13'(YEAR_474)
				+ (base_neg_s11 ? (13'd0 - bm_u) : bm_u));
			bq_s12   <= base_neg_s11 ? $signed(5'd0 - bq_u) : $signed(bq_u);
			year_s12 <= year_s11;
			jdn_s12  <= jdn_s11;
		end
	end

	// ---- stage 13: leap-day numerator of the forward formula
	logic [22:0] tv;
	logic [22:0] tv_abs;

	always_comb begin
		tv     = $unsigned(23'(epy_s12)) * EPY_MUL - 23'd110;
		tv_abs = tv[22] ? (23'd0 - tv) : tv;
	end

	logic               t_neg_s13;
	logic [21:0]        t_mag_s13;
	logic signed [12:0] epy_s13;
	logic signed [4:0]  bq_s13;
	logic signed [16:0] year_s13;
	logic [22:0]        jdn_s13;

	always_ff @(posedge clk) begin
		if (adv[13]) begin
			t_neg_s13 <= tv[22];
			t_mag_s13 <= tv_abs[21:0];
			epy_s13   <= epy_s12;
			bq_s13    <= bq_s12;
			year_s13  <= year_s12;
			jdn_s13   <= jdn_s12;
		end
	end

	// ---- stage 14: divide by 2816
	logic [44:0] p2816;
	logic [11:0] tq_u;

	always_comb begin
		p2816 = 45'(t_mag_s13) * 45'(M_2816);
		tq_u  = {1'b0, p2816[44:34]};
	end

	logic signed [11:0] tq_s14;
	logic signed [12:0] epy_s14;
	logic signed [4:0]  bq_s14;
	logic signed [16:0] year_s14;
	logic [22:0]        jdn_s14;

	always_ff @(posedge clk) begin
		if (adv[14]) begin
			tq_s14   <= t_neg_s13 ? $signed(12'd0 - tq_u) : $signed(tq_u);
			epy_s14  <= epy_s13;
			bq_s14   <= bq_s13;
			year_s14 <= year_s13;
			jdn_s14  <= jdn_s13;
		end
	end

	// ---- stage 15: day number of 1 Farvardin
	logic [25:0] pdn_u;

	assign pdn_u = $unsigned(26'(tq_s14)) + ($unsigned(26'(epy_s14)) - 26'd1) * 26'd365
		+ $unsigned(26'(bq_s14)) * 26'(CYCLE_DAYS) + PERSIAN_BASE + 26'd1;

	logic [25:0]        pdn_s15;
	logic signed [16:0] year_s15;
	logic [22:0]        jdn_s15;

	always_ff @(posedge clk) begin
		if (adv[15]) begin
			pdn_s15  <= pdn_u;
			year_s15 <= year_s14;
			jdn_s15  <= jdn_s14;
		end
	end

	// ---- stage 16: day of year
	logic signed [25:0] dy_s16;
	logic signed [16:0] year_s16;

	always_ff @(posedge clk) begin
		if (adv[16]) begin
			dy_s16   <= $signed(26'(jdn_s15) - pdn_s15 + 26'd1);
			year_s16 <= year_s15;
		end
	end

	// ---- stage 17: month ceiling operand
	logic        le186;
	logic [25:0] v_u;
	logic        v_pos;

	always_comb begin
		le186 = (dy_s16 <= 26'sd186);
		v_u   = le186 ? $unsigned(dy_s16) : ($unsigned(dy_s16) - 26'd6);
		v_pos = ($signed(v_u) > 26'sd0);
	end

	logic               le186_s17;
	logic               v_pos_s17;
	logic [25:0]        vmag_s17;
	logic signed [25:0] dy_s17;
	logic signed [16:0] year_s17;

	always_ff @(posedge clk) begin
		if (adv[17]) begin
			le186_s17 <= le186;
			v_pos_s17 <= v_pos;
			vmag_s17  <= v_pos ? (v_u + (le186 ? 26'd30 : 26'd29)) : (26'd0 - v_u);
			dy_s17    <= dy_s16;
			year_s17  <= year_s16;
		end
	end

	// ---- stage 18: month, 31-day months first then 30-day months
	logic [52:0] pmon;
	logic [25:0] mq_u;

	always_comb begin
		pmon = 53'(vmag_s17) * 53'(le186_s17 ? M_31 : M_30);
		mq_u = 26'(pmon[52:31]);
	end

	logic signed [25:0] mon_s18;
	logic signed [25:0] dy_s18;
	logic signed [16:0] year_s18;

	always_ff @(posedge clk) begin
		if (adv[18]) begin
			mon_s18  <= v_pos_s17 ? $signed(mq_u) : $signed(26'd0 - mq_u);
			dy_s18   <= dy_s17;
			year_s18 <= year_s17;
		end
	end

	// ---- stage 19: day of month, result register
	logic [25:0] off_u;

	always_comb begin
		if (mon_s18 <= 26'sd7) begin
			off_u = ($unsigned(mon_s18) - 26'd1) * 26'd31;
		end else begin
			off_u = ($unsigned(mon_s18) - 26'd1) * 26'd30 + 26'd6;
		end
	end

	logic signed [14:0] year_s19;
	logic [3:0]         mon_s19;
	logic [4:0]         mday_s19;
	logic [8:0]         yday_s19;
	logic [25:0]        mday_u;

	assign mday_u = $unsigned(dy_s18) - off_u;

	always_ff @(posedge clk) begin
		if (adv[19]) begin
			year_s19 <= year_s18[14:0];
			mon_s19  <= mon_s18[3:0];
			mday_s19 <= mday_u[4:0];
			yday_s19 <= dy_s18[8:0];
		end
	end

	always_comb begin
		jalali.persian_year  = year_s19;
		jalali.persian_month = mon_s19;
		jalali.persian_day   = mday_s19;
		jalali.day_in_year   = yday_s19;
	end

endmodule

`default_nettype wire

// File: rtl/gjd_checker.sv
// ----------------------------------------------------------------------------
// gjd_checker
// Port-level checks for the date converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gjd_checker
	import gjd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         greg_valid,
	input logic         greg_stall,
	input greg_date_t   greg,
	input logic         jalali_valid,
	input logic         jalali_stall,
	input jalali_date_t jalali
);

	// the pipe only backs up once the result is held by the receiver
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		greg_stall |-> (jalali_valid && jalali_stall))
		else $error("request stalled while result side is free");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(jalali_valid && jalali_stall) |=> (jalali_valid && $stable(jalali)))
		else $error("stalled result changed or dropped");

	// a stalled request stays on the port unchanged
	a_hold_request: assert property (@(posedge clk) disable iff (!arst_n)
		(greg_valid && greg_stall) |=> (greg_valid && $stable(greg)))
		else $error("stalled request changed or dropped");

	// year zero is skipped
	a_year_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		jalali_valid |-> (jalali.persian_year != 15'sd0))
		else $error("jalali year is zero");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !jalali_valid)
		else $error("result valid right after reset");

endmodule

bind gregorian_to_jalali_date gjd_checker u_gjd_checker (.*);

`default_nettype wire

// File: bench/tb_gregorian_to_jalali_date.sv
// ----------------------------------------------------------------------------
// tb_gregorian_to_jalali_date
// Drives civil dates into the converter, predicts each Jalali result with an
// integer model of the day-number and 2820-year cycle arithmetic, and checks
// results in order under random gaps on the request channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_gregorian_to_jalali_date;
	import gjd_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         greg_valid;
	logic         greg_stall;
	greg_date_t   greg;
	logic         jalali_valid;
	logic         jalali_stall;
	jalali_date_t jalali;

	jalali_date_t pending_dates[$];
	int           errors;
	int           cycles;
	int           hold_off;
	bit           stall_enable;

	localparam int CYCLE_LIMIT = 400000;

	gregorian_to_jalali_date i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.greg_valid   (greg_valid),
		.greg_stall   (greg_stall),
		.greg         (greg),
		.jalali_valid (jalali_valid),
		.jalali_stall (jalali_stall),
		.jalali       (jalali)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// truncating division as in C, on 64-bit signed values
	function automatic longint tdiv(longint n, longint d);
		longint q;
		q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function automatic longint tmod(longint n, longint d);
		return n - tdiv(n, d) * d;
	endfunction

	function automatic longint month_days_before(longint m);
		if (m <= 7)
			return (m - 1) * 31;
		return (m - 1) * 30 + 6;
	endfunction

	function automatic longint jalali_day_number(longint y, longint m, longint d);
		longint base, epy;
		base = y - 473;
		if (y >= 0)
			base = base - 1;
		epy = 474 + tmod(base, 2820);
		return d + month_days_before(m) + tdiv(epy * 682 - 110, 2816) + (epy - 1) * 365
			+ tdiv(base, 2820) * 1029983 + 1948320;
	endfunction

	function automatic longint ceil_quot(longint n, longint d);
		if (n > 0)
			return tdiv(n + d - 1, d);
		return tdiv(n, d);
	endfunction

	function automatic jalali_date_t convert_date(greg_date_t g);
		longint gy, gm, gd, jdn, dep, cyc, rem, ycyc, year, dy, mon, mday, q, a;
		jalali_date_t r;
		gy = g.greg_year;
		gm = g.greg_month;
		gd = g.greg_day;
		if (gy > 1582 || (gy == 1582 && gm > 10) || (gy == 1582 && gm == 10 && gd > 14)) begin
			q = tdiv(gm - 14, 12);
			jdn = tdiv(1461 * (gy + 4800 + q), 4) + tdiv(367 * (gm - 2 - 12 * q), 12)
				- tdiv(3 * tdiv(gy + 4900 + q, 100), 4) + gd - 32075;
		end else begin
			jdn = 367 * gy - tdiv(7 * (gy + 5001 + tdiv(gm - 9, 7)), 4)
				+ tdiv(275 * gm, 9) + gd + 1729777;
		end
		dep = jdn - 2121446;
		cyc = tdiv(dep, 1029983);
		rem = tmod(dep, 1029983);
		if (rem == 1029982) begin
			ycyc = 2820;
		end else begin
			a = tdiv(rem, 366);
			ycyc = tdiv(2134 * a + 2816 * tmod(rem, 366) + 2815, 1028522) + a + 1;
		end
		year = ycyc + 2820 * cyc + 474;
		if (year <= 0)
			year = year - 1;
		dy = jdn - jalali_day_number(year, 1, 1) + 1;
		if (dy <= 186)
			mon = ceil_quot(dy, 31);
		else
			mon = ceil_quot(dy - 6, 30);
		mday = jdn - jalali_day_number(year, mon, 1) + 1;
		r.persian_year = year[14:0];
		r.persian_month = mon[3:0];
		r.persian_day = mday[4:0];
		r.day_in_year = 9'(month_days_before(mon) + mday);
		return r;
	endfunction

	function automatic int idle_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 3);
	endfunction

	// one request, with an optional random gap ahead of it; valid stays high
	// after acceptance so the next request can follow back to back
	task automatic send_date(greg_date_t g, bit gaps);
		int n;
		n = gaps ? idle_len() : 0;
		if (n > 0) begin
			greg_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		greg <= g;
		greg_valid <= 1'b1;
		do @(posedge clk); while (greg_stall);
		pending_dates.push_back(convert_date(g));
		@(negedge clk);
	endtask

	function automatic greg_date_t mk(int y, int m, int d);
		greg_date_t g;
		g.greg_year = 14'(y);
		g.greg_month = 4'(m);
		g.greg_day = 5'(d);
		return g;
	endfunction

	task automatic test_directed();
		send_date(mk(1, 1, 1), 0);
		send_date(mk(9999, 12, 31), 0);
		send_date(mk(16383, 15, 31), 0);
		send_date(mk(0, 0, 0), 0);
		send_date(mk(1582, 10, 4), 0);
		send_date(mk(1582, 10, 5), 0);
		send_date(mk(1582, 10, 14), 0);
		send_date(mk(1582, 10, 15), 0);
		send_date(mk(1582, 11, 1), 0);
		send_date(mk(621, 3, 21), 0);
		send_date(mk(622, 3, 22), 0);
		send_date(mk(2000, 2, 29), 0);
		send_date(mk(2024, 3, 20), 0);
		send_date(mk(2025, 3, 21), 0);
		send_date(mk(1979, 9, 23), 0);
		send_date(mk(3000, 13, 0), 0);
		send_date(mk(5000, 14, 31), 0);
		send_date(mk(10000, 1, 1), 0);
	endtask

	task automatic test_random(int count);
		greg_date_t g;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				g = 23'($urandom);
			else
				g = mk($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 31));
			send_date(g, 1);
		end
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		hold_off = 120;
		for (int i = 0; i < 60; i++)
			send_date(mk($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28)), 0);
	endtask

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			jalali_stall <= 1'b1;
		end else if (stall_enable) begin
			jalali_stall <= ($urandom_range(0, 3) == 0) ||
				($urandom_range(0, 59) == 0 ? 1'b1 : 1'b0);
		end else begin
			jalali_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		jalali_date_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
		if (arst_n && jalali_valid && !jalali_stall) begin
			if (pending_dates.size() == 0) begin
				$display("%0t unexpected result %p", $time, jalali);
				errors++;
			end else begin
				want = pending_dates.pop_front();
				if (jalali.persian_year !== want.persian_year)
					$display("%0t persian_year exp %0d got %0d", $time,
						want.persian_year, jalali.persian_year);
				if (jalali.persian_month !== want.persian_month)
					$display("%0t persian_month exp %0d got %0d", $time,
						want.persian_month, jalali.persian_month);
				if (jalali.persian_day !== want.persian_day)
					$display("%0t persian_day exp %0d got %0d", $time,
						want.persian_day, jalali.persian_day);
				if (jalali.day_in_year !== want.day_in_year)
					$display("%0t day_in_year exp %0d got %0d", $time,
						want.day_in_year, jalali.day_in_year);
				if (jalali !== want)
					errors++;
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		hold_off = 0;
		stall_enable = 1'b0;
		arst_n = 1'b0;
		greg_valid = 1'b0;
		greg = '0;
		jalali_stall = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		stall_enable = 1'b1;
		test_random(500);
		test_backpressure();
		test_random(470);
		greg_valid <= 1'b0;
		stall_enable = 1'b0;
		wait (pending_dates.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_dates.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
